// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that is checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hdl/eulxyz_pkg.sv =====
// Package with types, constants and helper functions of the Euler matrix block.
`default_nettype none
package eulxyz_pkg;
   localparam int ANGLE_BITS  = 16;
   localparam int FRAC_BITS   = 15;
   localparam int TRIG_STAGES = 16;
   localparam int STAGES      = (TRIG_STAGES > 32) ? 32 : TRIG_STAGES;
   localparam int TW          = FRAC_BITS + 2;
   localparam int PW          = 2 * TW;
   localparam int SW          = TW + 2;
   localparam logic signed [35:0] CORDIC_GAIN = 36'sd2608131496;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] angle_x;
      logic signed [ANGLE_BITS-1:0] angle_y;
      logic signed [ANGLE_BITS-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] row0_col0;
      logic signed [15:0] row1_col0;
      logic signed [15:0] row2_col0;
      logic signed [15:0] row0_col1;
      logic signed [15:0] row1_col1;
      logic signed [15:0] row2_col1;
      logic signed [15:0] row0_col2;
      logic signed [15:0] row1_col2;
      logic signed [15:0] row2_col2;
   } rsp_type;

   typedef struct packed {
      logic signed [TW-1:0] s;
      logic signed [TW-1:0] c;
   } sc_type;

   function automatic logic [31:0] atan_lut(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
         5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
         5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
         5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
         5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001; default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // Rounded product of two trig-scale values, kept at product width.
   function automatic logic signed [PW-1:0] qmul(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b);
      logic signed [2*SW-1:0] p;
      p = a * b + (2*SW)'(1 << (FRAC_BITS - 1));
      return PW'(p >>> FRAC_BITS);
   endfunction

   // Convert a Q.FRAC_BITS value to saturated Q1.15.
   function automatic logic signed [15:0] to_q15(input logic signed [PW-1:0] e);
      logic signed [PW+16:0] v;
      v = (PW+17)'(e);
      if (FRAC_BITS > 15)
         v = (v + (PW+17)'(1 << ((FRAC_BITS > 15) ? FRAC_BITS - 16 : 0)))
             >>> ((FRAC_BITS > 15) ? FRAC_BITS - 15 : 0);
      else
         v = v <<< ((FRAC_BITS < 15) ? 15 - FRAC_BITS : 0);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction
endpackage
`default_nettype wire

// ===== hdl/eulxyz_cordic.sv =====
// Pipelined CORDIC giving sine and cosine of one binary angle.
`default_nettype none
module eulxyz_cordic (
   input  wire logic                                   clock,
   input  wire logic [eulxyz_pkg::ANGLE_BITS-1:0]      angle,
   output eulxyz_pkg::sc_type                          sc
);
   localparam int N = eulxyz_pkg::STAGES;
   logic signed [35:0] x_ff [0:N];
   logic signed [35:0] y_ff [0:N];
   logic signed [32:0] z_ff [0:N];
   logic               flip_ff [0:N];
   logic [31:0]        phase_in;
   logic               flip_in;
   logic signed [35:0] xr_in, yr_in;
   logic signed [35:0] cr_in, sr_in;

   always_comb begin
      phase_in = 32'(angle) << (32 - eulxyz_pkg::ANGLE_BITS);
      flip_in  = (phase_in[31:30] == 2'b01) || (phase_in[31:30] == 2'b10);
      if (flip_in) phase_in = phase_in + 32'h80000000;
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= eulxyz_pkg::CORDIC_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= 33'(signed'(phase_in));
      flip_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [35:0] dx, dy;
      logic signed [32:0] a;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign a  = 33'(eulxyz_pkg::atan_lut(5'(i)));
      always_ff @(posedge clock) begin
         if (!z_ff[i][32]) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - a;
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + a;
         end
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   localparam int SH = 32 - eulxyz_pkg::FRAC_BITS;
   localparam logic signed [35:0] ONE = 36'sd1 <<< eulxyz_pkg::FRAC_BITS;
   always_comb begin
      xr_in = flip_ff[N] ? -x_ff[N] : x_ff[N];
      yr_in = flip_ff[N] ? -y_ff[N] : y_ff[N];
      cr_in = (xr_in + (36'sd1 <<< (SH - 1))) >>> SH;
      sr_in = (yr_in + (36'sd1 <<< (SH - 1))) >>> SH;
      if (cr_in > ONE) cr_in = ONE;
      if (cr_in < -ONE) cr_in = -ONE;
      if (sr_in > ONE) sr_in = ONE;
      if (sr_in < -ONE) sr_in = -ONE;
   end

   always_ff @(posedge clock) begin
      sc.c <= cr_in[eulxyz_pkg::TW-1:0];
      sc.s <= sr_in[eulxyz_pkg::TW-1:0];
   end
endmodule
`default_nettype wire

// ===== hdl/eulxyz_matrix.sv =====
// Three-stage product pipeline forming the nine matrix entries.
`default_nettype none
module eulxyz_matrix (
   input  wire logic                clock,
   input  eulxyz_pkg::sc_type       scx,
   input  eulxyz_pkg::sc_type       scy,
   input  eulxyz_pkg::sc_type       scz,
   output eulxyz_pkg::rsp_type      rsp
);
   localparam int SW = eulxyz_pkg::SW;
   localparam int PW = eulxyz_pkg::PW;
   typedef logic signed [SW-1:0] s_type;
   typedef logic signed [PW-1:0] p_type;
   s_type sr, cr, sp, cp, sw, cw;
   p_type srsp_ff, crsp_ff, cpcw_ff, cpsw_ff, srcp_ff, crcp_ff, crsw_ff, crcw_ff;
   p_type srsw_ff, srcw_ff, nsp_ff;
   s_type sw_ff, cw_ff;
   p_type a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff, i_ff;

   assign sr = SW'(scx.s); assign cr = SW'(scx.c);
   assign sp = SW'(scy.s); assign cp = SW'(scy.c);
   assign sw = SW'(scz.s); assign cw = SW'(scz.c);

   always_ff @(posedge clock) begin
      srsp_ff <= eulxyz_pkg::qmul(sr, sp);
      crsp_ff <= eulxyz_pkg::qmul(cr, sp);
      cpcw_ff <= eulxyz_pkg::qmul(cp, cw);
      cpsw_ff <= eulxyz_pkg::qmul(cp, sw);
      srcp_ff <= eulxyz_pkg::qmul(sr, cp);
      crcp_ff <= eulxyz_pkg::qmul(cr, cp);
      crsw_ff <= eulxyz_pkg::qmul(cr, sw);
      crcw_ff <= eulxyz_pkg::qmul(cr, cw);
      srsw_ff <= eulxyz_pkg::qmul(sr, sw);
      srcw_ff <= eulxyz_pkg::qmul(sr, cw);
      nsp_ff  <= -PW'(sp);
      sw_ff   <= sw;
      cw_ff   <= cw;
   end

   always_ff @(posedge clock) begin
      a_ff <= cpcw_ff;
      b_ff <= cpsw_ff;
      c_ff <= nsp_ff;
      d_ff <= eulxyz_pkg::qmul(SW'(srsp_ff), cw_ff) - crsw_ff;
      e_ff <= eulxyz_pkg::qmul(SW'(srsp_ff), sw_ff) + crcw_ff;
      f_ff <= srcp_ff;
      g_ff <= eulxyz_pkg::qmul(SW'(crsp_ff), cw_ff) + srsw_ff;
      h_ff <= eulxyz_pkg::qmul(SW'(crsp_ff), sw_ff) - srcw_ff;
      i_ff <= crcp_ff;
   end

   always_ff @(posedge clock) begin
      rsp.row0_col0 <= eulxyz_pkg::to_q15(a_ff);
      rsp.row1_col0 <= eulxyz_pkg::to_q15(b_ff);
      rsp.row2_col0 <= eulxyz_pkg::to_q15(c_ff);
      rsp.row0_col1 <= eulxyz_pkg::to_q15(d_ff);
      rsp.row1_col1 <= eulxyz_pkg::to_q15(e_ff);
      rsp.row2_col1 <= eulxyz_pkg::to_q15(f_ff);
      rsp.row0_col2 <= eulxyz_pkg::to_q15(g_ff);
      rsp.row1_col2 <= eulxyz_pkg::to_q15(h_ff);
      rsp.row2_col2 <= eulxyz_pkg::to_q15(i_ff);
   end
endmodule
`default_nettype wire

// ===== hdl/euler_xyz_rotation_matrix.sv =====
// Top level of the xyz Euler angle to rotation matrix block.
// One transaction enters per cycle and busy stays low; each result appears
// on rsp_data with rsp_valid high for one cycle, after passing through the
// angle input register, the CORDIC rotation pipeline (sixteen rotations),
// the rounding register, two product stages and the output saturation
// stage.
// The receiver cannot stall, so no result is ever held back.
`default_nettype none
`include "assert_macros.svh"
module euler_xyz_rotation_matrix (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  eulxyz_pkg::req_type      req_data,
   output      logic                rsp_valid,
   output eulxyz_pkg::rsp_type      rsp_data
);
   localparam int LAT = eulxyz_pkg::STAGES + 5;
   eulxyz_pkg::sc_type scx, scy, scz;
   logic [LAT-1:0] vld_ff;

   assign busy = 1'b0;

   eulxyz_cordic u_cx (.clock(clock), .angle(req_data.angle_x), .sc(scx));
   eulxyz_cordic u_cy (.clock(clock), .angle(req_data.angle_y), .sc(scy));
   eulxyz_cordic u_cz (.clock(clock), .angle(req_data.angle_z), .sc(scz));
   eulxyz_matrix u_mat (.clock(clock), .scx(scx), .scy(scy), .scz(scz), .rsp(rsp_data));

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LAT-2:0], start & ~busy};
   end
   assign rsp_valid = vld_ff[LAT-1];

   `ASSERT_NEXT(a_vld_shift, clock, reset, start && !busy && !reset, vld_ff[0], "start lost in valid line")
   `ASSERT_IMPLY(a_no_busy, clock, reset, 1'b1, !busy, "busy raised")
   `ASSERT_NEXT(a_out, clock, reset, vld_ff[LAT-2] && !reset, rsp_valid, "result strobe lost")
endmodule
`default_nettype wire
